// ===== src/dq_pkg.sv =====
// Package of the double-ended queue: sizes, operation and status codes, result type.
package dq_pkg;

    // Ring size and derived widths
    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    // One result as held in the output queue
    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     has_value;
        logic                     is_last;
        logic [STAT_W-1:0]        status;
        logic                     is_empty;
        logic [COUNT_W-1:0]       count;
    } t_res;

endpackage

// ===== src/dq_if.sv =====
// Request and result channel interfaces of the double-ended queue.
interface dq_req_if;
    logic                                valid;
    logic                                ready;
    logic [dq_pkg::OP_W-1:0]             op;
    logic signed [dq_pkg::DATA_W-1:0]    value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface dq_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [dq_pkg::DATA_W-1:0]    value_res;
    logic                                has_value;
    logic                                is_last;
    logic [dq_pkg::STAT_W-1:0]           status;
    logic                                is_empty;
    logic [dq_pkg::COUNT_W-1:0]          count;

    modport source (output valid, output value_res, output has_value, output is_last,
                    output status, output is_empty, output count, input ready);
    modport sink   (input valid, input value_res, input has_value, input is_last,
                    input status, input is_empty, input count, output ready);
endinterface

// ===== src/double_ended_queue.sv =====
// Double-ended queue: ring buffer memory, op sequencer and two-entry result queue.
//
// Bounded deque of signed 32-bit values kept in a DEPTH-entry ring memory with a
// registered synchronous read. Push and pop requests give one result each; a new
// request is taken whenever the two-entry result queue has room and no list is
// running. A list request streams the stored values front to back, one memory read
// and one result per cycle while the result queue has room (a list on an empty deque
// gives a single result); the single memory read port sets that rate.
// Results leave through the result queue, so a stalled sink does not lose data.
module double_ended_queue (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_req_if.sink   i_in,
    dq_res_if.source o_out
);
    import dq_pkg::*;

    // Ring index wrap for sums below twice the depth
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] s);
        logic [IDX_W:0] d;
        d = (s >= (IDX_W+1)'(DEPTH)) ? (s - (IDX_W+1)'(DEPTH)) : s;
        return d[IDX_W-1:0];
    endfunction

    // Ring storage and control state
    logic signed [DATA_W-1:0] r_slots [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;
    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_front, n_front;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_pend, n_pend;
    logic                     r_pend_last, n_pend_last;

    // Result queue
    t_res                     r_q [2];
    logic                     r_q_wp, r_q_rp;
    logic [1:0]               r_q_cnt;

    logic                     in_acc, deq;
    logic                     mem_we, rd_en;
    logic [IDX_W-1:0]         mem_waddr, rd_addr;
    logic                     q_wr;
    t_res                     q_wdata;
    logic                     full, empty;
    logic [2:0]               occ;

    assign full   = (r_count == CNT_W'(DEPTH));
    assign empty  = (r_count == '0);
    assign deq    = o_out.valid && o_out.ready;
    assign in_acc = i_in.valid && i_in.ready;
    assign occ    = {1'b0, r_q_cnt} + {2'b00, r_pend};

    assign i_in.ready = (r_state == S_IDLE) && !r_pend && (r_q_cnt < 2'd2);

    // Sequencer: op decode, ring updates and list read issue
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        mem_we      = 1'b0;
        mem_waddr   = r_front;
        rd_en       = 1'b0;
        rd_addr     = wrap_idx({1'b0, r_front} + {1'b0, r_idx});
        q_wr        = 1'b0;
        q_wdata     = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    q_wr              = 1'b1;
                    q_wdata.is_last   = 1'b1;
                    q_wdata.status    = ST_OK;
                    case (i_in.op)
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                q_wdata.status = ST_FULL;
                            end else begin
                                n_front   = (r_front == '0) ? IDX_W'(DEPTH - 1)
                                                            : r_front - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = n_front;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (full) begin
                                q_wdata.status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = wrap_idx({1'b0, r_front} + (IDX_W+1)'(r_count));
                                n_count   = r_count + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (empty) begin
                                q_wdata.status = ST_EMPTY;
                            end else begin
                                n_front = wrap_idx({1'b0, r_front} + 1'b1);
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (empty) begin
                                q_wdata.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_LIST: begin
                            // empty list still answers once; otherwise stream
                            if (!empty) begin
                                q_wr    = 1'b0;
                                n_state = S_LIST;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    q_wdata.is_empty = (n_count == '0);
                    q_wdata.count    = COUNT_W'(n_count);
                end
            end
            S_LIST: begin
                // issue a read only when its result will find room
                if ((occ < 3'd2) || ((occ == 3'd2) && deq)) begin
                    rd_en       = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = ({1'b0, r_idx} == CNT_W'(r_count - 1'b1));
                    n_idx       = r_idx + 1'b1;
                    if (n_pend_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // read data from the previous cycle becomes a list result
        if (r_pend) begin
            q_wr              = 1'b1;
            q_wdata.value_res = r_rd_data;
            q_wdata.has_value = 1'b1;
            q_wdata.is_last   = r_pend_last;
            q_wdata.status    = ST_OK;
            q_wdata.is_empty  = empty;
            q_wdata.count     = COUNT_W'(r_count);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
        r_pend_last <= n_pend_last;
    end

    // Ring memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slots[mem_waddr] <= i_in.value;
        end
        if (rd_en) begin
            r_rd_data <= r_slots[rd_addr];
        end
    end

    // Result queue pointers and storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= 1'b0;
            r_q_rp  <= 1'b0;
            r_q_cnt <= '0;
        end else begin
            if (q_wr) begin
                r_q_wp <= ~r_q_wp;
            end
            if (deq) begin
                r_q_rp <= ~r_q_rp;
            end
            r_q_cnt <= r_q_cnt + {1'b0, q_wr} - {1'b0, deq};
        end
        if (q_wr) begin
            r_q[r_q_wp] <= q_wdata;
        end
    end

    // Result channel
    assign o_out.valid     = (r_q_cnt != '0);
    assign o_out.value_res = r_q[r_q_rp].value_res;
    assign o_out.has_value = r_q[r_q_rp].has_value;
    assign o_out.is_last   = r_q[r_q_rp].is_last;
    assign o_out.status    = r_q[r_q_rp].status;
    assign o_out.is_empty  = r_q[r_q_rp].is_empty;
    assign o_out.count     = r_q[r_q_rp].count;

endmodule

// ===== src/dq_checker.sv =====
// Port-level checks of the double-ended queue result stream, bound to the top level.
module dq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [dq_pkg::DATA_W-1:0]  i_value_res,
    input logic                              i_has_value,
    input logic                              i_is_last,
    input logic [dq_pkg::STAT_W-1:0]         i_status,
    input logic                              i_is_empty,
    input logic [dq_pkg::COUNT_W-1:0]        i_count
);
    import dq_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value_res)
            && $stable(i_is_last) && $stable(i_status) && $stable(i_count))
        else $error("result changed while stalled");

    // empty flag agrees with count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_empty == (i_count == '0)))
        else $error("empty flag and count disagree");

    // count bounded by ring size
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_count) <= DEPTH))
        else $error("count above depth");

    // listed values always carry ok status
    a_list_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_has_value |-> (i_status == ST_OK))
        else $error("listed value with error status");

    // a result without a value is the only result of its request
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_has_value |-> i_is_last && (i_value_res == '0))
        else $error("valueless result not marked last");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_value_res (o_out.value_res),
    .i_has_value (o_out.has_value),
    .i_is_last   (o_out.is_last),
    .i_status    (o_out.status),
    .i_is_empty  (o_out.is_empty),
    .i_count     (o_out.count)
);

// ===== tb/sv/dq_result_checker.sv =====
// Result checker of the double-ended queue: watches both channels, predicts and compares.
module dq_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dq_req_if    i_req,
    dq_res_if    i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_req_count,
    output int   o_res_count,
    output int   o_list_count,
    output int   o_full_count,
    output int   o_empty_count,
    output int   o_peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int MAX_REPORTS = 40;

    // Shadow copy of the deque
    logic signed [DATA_W-1:0] ring_mem [DEPTH];
    int head_idx = 0;
    int fill     = 0;

    // Results still owed by the block, oldest first
    t_res awaited_results [$];

    int fail_cnt   = 0;
    int report_cnt = 0;
    int req_cnt    = 0;
    int res_cnt    = 0;
    int list_cnt   = 0;
    int full_cnt   = 0;
    int empty_cnt  = 0;
    int peak_fill  = 0;

    // Result stamped with the occupancy after the request
    function automatic t_res make_result(logic signed [DATA_W-1:0] val, logic has,
                                         logic last, t_status st);
        t_res r;
        r.value_res = val;
        r.has_value = has;
        r.is_last   = last;
        r.status    = st;
        r.is_empty  = (fill == 0);
        r.count     = COUNT_W'(fill);
        return r;
    endfunction

    // Apply one request to the shadow deque and queue the results it owes
    function automatic void apply_deque_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
        t_status st;
        st = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (fill == DEPTH) begin
                    st = ST_FULL;
                    full_cnt++;
                end else if (op == OP_PUSH_FRONT) begin
                    head_idx = (head_idx + DEPTH - 1) % DEPTH;
                    ring_mem[head_idx] = val;
                    fill++;
                end else begin
                    // on an empty deque this slot is the front as well
                    ring_mem[(head_idx + fill) % DEPTH] = val;
                    fill++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (fill == 0) begin
                    st = ST_EMPTY;
                    empty_cnt++;
                end else begin
                    if (op == OP_POP_FRONT) head_idx = (head_idx + 1) % DEPTH;
                    fill--;
                end
            end
            OP_LIST: list_cnt++;
            default: ;  // unused codes leave the deque alone
        endcase

        if (op == OP_LIST && fill != 0) begin
            for (int i = 0; i < fill; i++) begin
                awaited_results.push_back(make_result(ring_mem[(head_idx + i) % DEPTH],
                                                      1'b1, i == fill - 1, ST_OK));
            end
        end else begin
            awaited_results.push_back(make_result('0, 1'b0, 1'b1, st));
        end
        if (fill > peak_fill) peak_fill = fill;
    endfunction

    // One field of one result
    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want) begin
            fail_cnt++;
            if (report_cnt < MAX_REPORTS) begin
                report_cnt++;
                $display("%0t: result %0d field %s: expected 0x%0h, got 0x%0h",
                         $time, res_cnt, name, want, got);
            end
        end
    endfunction

    // Compare an accepted result with the oldest one owed
    function automatic void check_result();
        t_res want;
        if (awaited_results.size() == 0) begin
            fail_cnt++;
            if (report_cnt < MAX_REPORTS) begin
                report_cnt++;
                $display("%0t: result %0d: expected none, got value 0x%0h status %0d count %0d",
                         $time, res_cnt, i_res.value_res, i_res.status, i_res.count);
            end
        end else begin
            want = awaited_results.pop_front();
            check_field("value_res", want.value_res, i_res.value_res);
            check_field("has_value", want.has_value, i_res.has_value);
            check_field("is_last",   want.is_last,   i_res.is_last);
            check_field("status",    want.status,    i_res.status);
            check_field("is_empty",  want.is_empty,  i_res.is_empty);
            check_field("count",     want.count,     i_res.count);
        end
        res_cnt++;
    endfunction

    // Results are checked before the request of the same edge is applied
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_idx = 0;
            fill     = 0;
            awaited_results.delete();
        end else begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) check_result();
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                req_cnt++;
                apply_deque_op(i_req.op, i_req.value);
            end
        end
        o_fail_count  <= fail_cnt;
        o_pending     <= awaited_results.size();
        o_req_count   <= req_cnt;
        o_res_count   <= res_cnt;
        o_list_count  <= list_cnt;
        o_full_count  <= full_cnt;
        o_empty_count <= empty_cnt;
        o_peak_fill   <= peak_fill;
    end

endmodule

// ===== tb/sv/tb_double_ended_queue.sv =====
// Testbench top of the double-ended queue: clock, reset, request stimulus and verdict.
module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int RAND_ITEMS  = 110;
    localparam int TAIL_CYCLES = 16;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_W'(OP_LIST + 1);
    localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN, MIX_LISTS} t_mix;
    typedef enum int {STALL_NONE, STALL_SOME, STALL_HEAVY} t_stall;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dq_req_if req_ch ();
    dq_res_if res_ch ();

    int fail_cnt, pending_cnt, req_cnt, res_cnt, list_cnt, full_cnt, empty_cnt, peak_fill;
    int cycle_cnt  = 0;
    int items_sent = 0;
    int burst_left = 0;
    int directed_items;
    t_stall stall_mode = STALL_NONE;
    int     stall_left = 0;

    double_ended_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    dq_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_cnt),
        .o_pending     (pending_cnt),
        .o_req_count   (req_cnt),
        .o_res_count   (res_cnt),
        .o_list_count  (list_cnt),
        .o_full_count  (full_cnt),
        .o_empty_count (empty_cnt),
        .o_peak_fill   (peak_fill)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed", cycle_cnt, pending_cnt);
            $display("Some tests failed");
            $finish;
        end
    end

    // Result sink: a random stall pattern, redrawn when its run counter runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode   <= t_stall'($urandom_range(STALL_NONE, STALL_HEAVY));
            stall_left   <= $urandom_range(8, 48);
            res_ch.ready <= 1'b1;
        end else begin
            stall_left <= stall_left - 1;
            case (stall_mode)
                STALL_NONE: res_ch.ready <= 1'b1;
                STALL_SOME: res_ch.ready <= ($urandom_range(0, 3) != 0);
                default:    res_ch.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Send one request; bursts end in a random gap
    task automatic send_req(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= val;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        items_sent++;
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 6);
        end else begin
            burst_left--;
        end
    endtask

    // Hold off until every owed result has come back
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
    endtask

    function automatic logic [OP_W-1:0] pick_op(t_mix mix);
        int r;
        int push_pct, pop_pct, list_pct;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   begin push_pct = 80; pop_pct = 10; list_pct = 6;  end
            MIX_SHRINK: begin push_pct = 15; pop_pct = 72; list_pct = 8;  end
            MIX_CHURN:  begin push_pct = 45; pop_pct = 40; list_pct = 10; end
            default:    begin push_pct = 35; pop_pct = 30; list_pct = 30; end
        endcase
        if (r < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (r < push_pct + pop_pct)
            return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        if (r < push_pct + pop_pct + list_pct)
            return OP_LIST;
        return OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    endfunction

    // Mostly random words, with the corner values now and then
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.op    <= OP_PUSH_FRONT;
        req_ch.value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-deque cases, unused codes, extremes, both ends
        send_req(OP_LIST, $urandom);
        send_req(OP_POP_FRONT, $urandom);
        send_req(OP_POP_BACK, $urandom);
        for (int u = OP_FIRST_UNUSED; u <= OP_LAST_UNUSED; u++) send_req(OP_W'(u), $urandom);
        send_req(OP_PUSH_BACK, 32'd123);        // push back on empty sets the front too
        send_req(OP_LIST, $urandom);
        send_req(OP_POP_FRONT, $urandom);
        send_req(OP_PUSH_BACK, -32'sd5);
        send_req(OP_PUSH_FRONT, 32'h8000_0000);
        send_req(OP_PUSH_BACK, 32'h7fff_ffff);
        send_req(OP_PUSH_FRONT, 32'h0000_0000);
        send_req(OP_PUSH_BACK, 32'hffff_ffff);
        send_req(OP_PUSH_FRONT, 32'h5555_5555);
        send_req(OP_PUSH_BACK, 32'haaaa_aaaa);
        send_req(OP_LIST, $urandom);
        send_req(OP_POP_FRONT, $urandom);
        send_req(OP_POP_BACK, $urandom);
        send_req(OP_LIST, $urandom);
        repeat (5) send_req($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
        directed_items = items_sent;
        hold_until_drained();

        // Fill past full, list the full ring, drain past empty
        repeat (DEPTH + 1)
            send_req($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
        send_req(OP_LIST, $urandom);
        repeat (DEPTH + 1)
            send_req($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
        hold_until_drained();

        // Random phases with shifting op mixes
        while (items_sent < directed_items + RAND_ITEMS) begin
            t_mix mix;
            mix = t_mix'($urandom_range(MIX_GROW, MIX_LISTS));
            repeat ($urandom_range(10, 30)) send_req(pick_op(mix), pick_value());
            if ($urandom_range(0, 2) == 0) hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d results in %0d cycles, peak fill %0d of %0d.",
                 req_cnt, res_cnt, cycle_cnt, peak_fill, DEPTH);
        $display("It saw %0d lists, %0d pushes rejected when full, %0d pops on empty.",
                 list_cnt, full_cnt, empty_cnt);
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/dq_pkg.sv
src/dq_if.sv
src/double_ended_queue.sv
src/dq_checker.sv
tb/sv/dq_result_checker.sv
tb/sv/tb_double_ended_queue.sv
